// ===== hw/rtl/ast_pkg.sv =====
// Shared constants, types and helpers for the angular spectrum kernel generator.
package ast_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int HALF_MAX   = MAX_DIM / 2;
  localparam int MOD_STEPS  = 10;   // conditional subtracts for (idx + h) mod 2h
  localparam int ROOT_STEPS = 24;   // one result bit per root cell
  localparam int POLY_STEPS = 4;    // Horner cells after the seed coefficient
  // stage numbers of the pipeline registers
  localparam int ST_ABS   = MOD_STEPS;
  localparam int ST_SQ    = ST_ABS + 1;
  localparam int ST_MUL   = ST_SQ + 1;
  localparam int ST_CMP   = ST_MUL + 1;
  localparam int ST_ROOT0 = ST_CMP + 1;
  localparam int ST_PHASE = ST_ROOT0 + ROOT_STEPS;
  localparam int ST_U2    = ST_PHASE + 1;
  localparam int ST_POLY0 = ST_U2 + 1;
  localparam int ST_FIN   = ST_POLY0 + POLY_STEPS;
  localparam int PIPE_DEPTH = ST_FIN + 1;

  // register indexes of the configuration port
  localparam logic [2:0] REG_INV_LAMBDA_SQ  = 3'd0;
  localparam logic [2:0] REG_COL_STEP_SQ    = 3'd1;
  localparam logic [2:0] REG_ROW_STEP_SQ    = 3'd2;
  localparam logic [2:0] REG_TURNS_PER_UNIT = 3'd3;
  localparam logic [2:0] REG_HALF_COLS      = 3'd4;
  localparam logic [2:0] REG_HALF_ROWS      = 3'd5;

  // quarter-wave sine polynomial, Q2.30
  localparam logic [31:0] PC_A9 = 32'd172272;
  localparam logic [31:0] HORNER_COEF [POLY_STEPS] =
    '{32'd5026995, 32'd85569306, 32'd693598669, 32'd1686629713};

  localparam logic [15:0] Q15_MAX = 16'sd32767;

  typedef struct packed {
    logic [30:0] u;    // argument, Q1.30
    logic [30:0] u2;   // argument squared, Q1.30
    logic [31:0] acc;  // Horner accumulator, Q2.30
  } lane_t;

  // zero means one, above the array half size saturates
  function automatic logic [9:0] eff_half(input logic [9:0] h);
    logic [9:0] v;
    v = h;
    if (h == 10'd0) v = 10'd1;
    else if (h > 10'(HALF_MAX)) v = 10'(HALF_MAX);
    return v;
  endfunction

endpackage

// ===== hw/rtl/ast_mod_cell.sv =====
// One conditional-subtract cell of the index modulo chain.
module ast_mod_cell import ast_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  shift,
  input  logic [9:0]  half,
  input  logic [10:0] rem_in,
  output logic [10:0] rem_r
);
  logic [20:0] dsh;
  logic [10:0] rem_nxt;

  assign dsh = {9'd0, half, 1'b0} << shift;

  always_comb begin
    rem_nxt = rem_in;
    if ({10'd0, rem_in} >= dsh) rem_nxt = rem_in - dsh[10:0];
  end

  always_ff @(posedge clk) begin
    if (en) rem_r <= rem_nxt;
  end
endmodule

// ===== hw/rtl/ast_root_cell.sv =====
// One bit step of the pipelined integer square root.
module ast_root_cell import ast_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  step,
  input  logic [47:0] n_in,
  input  logic [47:0] res_in,
  output logic [47:0] n_r,
  output logic [47:0] res_r
);
  logic [47:0] bitv;
  logic [48:0] trial;
  logic [47:0] n_nxt;
  logic [47:0] res_nxt;

  assign bitv  = 48'd1 << (6'd46 - {step, 1'b0});
  assign trial = {1'b0, res_in} + {1'b0, bitv};

  always_comb begin
    if ({1'b0, n_in} >= trial) begin
      n_nxt   = n_in - trial[47:0];
      res_nxt = (res_in >> 1) + bitv;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
    end
  end
endmodule

// ===== hw/rtl/ast_horner_cell.sv =====
// One Horner step of the sine polynomial: coef - (acc * u2) >> 30.
module ast_horner_cell import ast_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] coef,
  input  lane_t       lane_in,
  output lane_t       lane_r
);
  logic [62:0] prod;
  lane_t       lane_nxt;

  assign prod = {31'd0, lane_in.acc} * {32'd0, lane_in.u2};

  always_comb begin
    lane_nxt     = lane_in;
    lane_nxt.acc = coef - prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (en) lane_r <= lane_nxt;
  end
endmodule

// ===== hw/rtl/angular_spectrum_transfer_gen.sv =====
// Top level of the angular spectrum transfer function sample generator.
//
// Usage: each input transaction (in_row_index, in_col_index) names one sample
// of the quadrant-swapped kernel H = exp(i*2*pi*z*sqrt(1/lambda^2-fu^2-fv^2)).
// One output transaction returns re_part/im_part in Q1.15 and past_cutoff,
// which flags an evanescent sample (outputs then zero). Results leave in the
// order the indices came in, exactly one per input.
// Throughput: one transaction per cycle while the receiver keeps taking results.
// The pipeline has 46 register stages, the first loaded at input acceptance:
// 10 modulo cells, 4 arithmetic stages, 24 square-root cells (one root bit
// each), the phase multiply, 6 polynomial multiply stages and the output
// register.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken; in_ready follows that, so a stalled receiver holds every
// stage and no transaction is dropped.
// Reset (rst_n low, synchronous): pipeline empties, registers return to
// defaults (half sizes 512, all others 0).
// Configuration: cfg_we writes cfg_wdata to register cfg_addr. The user must
// write only while no transaction is in flight; the block does not enforce it.
module angular_spectrum_transfer_gen import ast_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         in_row_index,
  input  logic [9:0]         in_col_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_re_part,
  output logic signed [15:0] out_im_part,
  output logic               out_past_cutoff
);

  // ---------------- configuration registers ----------------
  logic [31:0] inv_lambda_sq_r, col_step_sq_r, row_step_sq_r, turns_per_unit_r;
  logic [9:0]  half_cols_r, half_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_lambda_sq_r  <= '0;
      col_step_sq_r    <= '0;
      row_step_sq_r    <= '0;
      turns_per_unit_r <= '0;
      half_cols_r      <= 10'(HALF_MAX);
      half_rows_r      <= 10'(HALF_MAX);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INV_LAMBDA_SQ:  inv_lambda_sq_r  <= cfg_wdata;
        REG_COL_STEP_SQ:    col_step_sq_r    <= cfg_wdata;
        REG_ROW_STEP_SQ:    row_step_sq_r    <= cfg_wdata;
        REG_TURNS_PER_UNIT: turns_per_unit_r <= cfg_wdata;
        REG_HALF_COLS:      half_cols_r      <= cfg_wdata[9:0];
        REG_HALF_ROWS:      half_rows_r      <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic [9:0] hc, hr;
  assign hc = eff_half(half_cols_r);
  assign hr = eff_half(half_rows_r);

  // ---------------- flow control ----------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end
  assign out_valid = out_valid_r;

  // ---------------- centring: (idx + h) mod 2h ----------------
  logic [10:0] remc [MOD_STEPS+1];
  logic [10:0] remr [MOD_STEPS+1];
  assign remc[0] = {1'b0, in_col_index} + {1'b0, hc};
  assign remr[0] = {1'b0, in_row_index} + {1'b0, hr};

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    ast_mod_cell u_col (.clk(clk), .en(adv), .shift(4'(MOD_STEPS - 1 - j)),
                        .half(hc), .rem_in(remc[j]), .rem_r(remc[j+1]));
    ast_mod_cell u_row (.clk(clk), .en(adv), .shift(4'(MOD_STEPS - 1 - j)),
                        .half(hr), .rem_in(remr[j]), .rem_r(remr[j+1]));
  end

  // ---------------- distance, square, scale, compare ----------------
  logic [9:0]  ac_r, ar_r;
  logic [18:0] sqc_r, sqr_r;
  logic [50:0] tc_r, tr_r;
  logic [51:0] terms;
  logic [31:0] rad_r;
  logic        cut_nxt;

  assign terms   = {1'b0, tc_r} + {1'b0, tr_r};
  assign cut_nxt = terms > {20'd0, inv_lambda_sq_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      ac_r  <= (remc[MOD_STEPS] >= {1'b0, hc}) ? 10'(remc[MOD_STEPS] - {1'b0, hc})
                                              : 10'({1'b0, hc} - remc[MOD_STEPS]);
      ar_r  <= (remr[MOD_STEPS] >= {1'b0, hr}) ? 10'(remr[MOD_STEPS] - {1'b0, hr})
                                              : 10'({1'b0, hr} - remr[MOD_STEPS]);
      sqc_r <= 19'({9'd0, ac_r} * {9'd0, ac_r});
      sqr_r <= 19'({9'd0, ar_r} * {9'd0, ar_r});
      tc_r  <= {32'd0, sqc_r} * {19'd0, col_step_sq_r};
      tr_r  <= {32'd0, sqr_r} * {19'd0, row_step_sq_r};
      rad_r <= inv_lambda_sq_r - terms[31:0];
    end
  end

  // cutoff flag travels alongside from the compare stage onward
  logic [ST_FIN:ST_CMP] cut_sr;
  always_ff @(posedge clk) begin
    if (adv) cut_sr <= {cut_sr[ST_FIN-1:ST_CMP], cut_nxt};
  end

  // ---------------- square root cells ----------------
  logic [47:0] rn  [ROOT_STEPS+1];
  logic [47:0] rres[ROOT_STEPS+1];
  assign rn[0]   = {rad_r, 16'd0};
  assign rres[0] = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    ast_root_cell u_cell (.clk(clk), .en(adv), .step(5'(k)),
                          .n_in(rn[k]), .res_in(rres[k]),
                          .n_r(rn[k+1]), .res_r(rres[k+1]));
  end

  // ---------------- phase in turns ----------------
  logic [55:0] phase_prod;
  logic [23:0] phase_r;
  assign phase_prod = {32'd0, rres[ROOT_STEPS][23:0]} * {24'd0, turns_per_unit_r};

  always_ff @(posedge clk) begin
    if (adv) phase_r <= phase_prod[39:16];
  end

  logic [1:0] quad_sr [ST_U2:ST_FIN];
  always_ff @(posedge clk) begin
    if (adv) begin
      quad_sr[ST_U2] <= phase_r[23:22];
      for (int i = ST_U2 + 1; i <= ST_FIN; i++) quad_sr[i] <= quad_sr[i-1];
    end
  end

  // ---------------- sine / cosine lanes ----------------
  logic [30:0] us, uc;
  logic [61:0] us_sq, uc_sq;
  lane_t       ls [POLY_STEPS+1];
  lane_t       lc [POLY_STEPS+1];

  assign us    = {1'b0, phase_r[21:0], 8'd0};
  assign uc    = {(23'h400000 - {1'b0, phase_r[21:0]}), 8'd0};
  assign us_sq = {31'd0, us} * {31'd0, us};
  assign uc_sq = {31'd0, uc} * {31'd0, uc};

  always_ff @(posedge clk) begin
    if (adv) begin
      ls[0] <= '{u: us, u2: us_sq[60:30], acc: PC_A9};
      lc[0] <= '{u: uc, u2: uc_sq[60:30], acc: PC_A9};
    end
  end

  for (genvar p = 0; p < POLY_STEPS; p++) begin : g_poly
    ast_horner_cell u_s (.clk(clk), .en(adv), .coef(HORNER_COEF[p]),
                         .lane_in(ls[p]), .lane_r(ls[p+1]));
    ast_horner_cell u_c (.clk(clk), .en(adv), .coef(HORNER_COEF[p]),
                         .lane_in(lc[p]), .lane_r(lc[p+1]));
  end

  logic [62:0] fs_prod, fc_prod;
  logic [32:0] fs_r, fc_r;
  assign fs_prod = {31'd0, ls[POLY_STEPS].acc} * {32'd0, ls[POLY_STEPS].u};
  assign fc_prod = {31'd0, lc[POLY_STEPS].acc} * {32'd0, lc[POLY_STEPS].u};

  always_ff @(posedge clk) begin
    if (adv) begin
      fs_r <= fs_prod[62:30];
      fc_r <= fc_prod[62:30];
    end
  end

  // ---------------- round, clamp, quadrant, output register ----------------
  logic [33:0] rs, rc;
  logic [15:0] s_q, c_q;
  logic [15:0] re_nxt, im_nxt;

  assign rs  = {1'b0, fs_r} + 34'h4000;
  assign rc  = {1'b0, fc_r} + 34'h4000;
  assign s_q = (rs[33:15] > {3'd0, Q15_MAX}) ? Q15_MAX : rs[30:15];
  assign c_q = (rc[33:15] > {3'd0, Q15_MAX}) ? Q15_MAX : rc[30:15];

  always_comb begin
    case (quad_sr[ST_FIN])
      2'd0:    begin re_nxt = c_q;       im_nxt = s_q;       end
      2'd1:    begin re_nxt = 16'd0 - s_q; im_nxt = c_q;     end
      2'd2:    begin re_nxt = 16'd0 - c_q; im_nxt = 16'd0 - s_q; end
      default: begin re_nxt = s_q;       im_nxt = 16'd0 - c_q; end
    endcase
    if (cut_sr[ST_FIN]) begin
      re_nxt = '0;
      im_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_re_part     <= re_nxt;
      out_im_part     <= im_nxt;
      out_past_cutoff <= cut_sr[ST_FIN];
    end
  end

endmodule

// ===== hw/rtl/ast_checker.sv =====
// Port-level checks for the kernel generator, bound to the top level.
module ast_checker import ast_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_re_part,
  input logic signed [15:0] out_im_part,
  input logic               out_past_cutoff
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_re_part)
      && $stable(out_im_part) && $stable(out_past_cutoff))
    else $error("result changed while stalled");

  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_past_cutoff |-> out_re_part == 16'sd0 && out_im_part == 16'sd0)
    else $error("evanescent sample not zero");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_re_part != -16'sd32768 && out_im_part != -16'sd32768)
    else $error("sample outside clamped range");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind angular_spectrum_transfer_gen ast_checker u_ast_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_re_part(out_re_part), .out_im_part(out_im_part),
  .out_past_cutoff(out_past_cutoff)
);

// ===== dv/angular_spectrum_transfer_gen_tb.sv =====
// Testbench for the angular spectrum kernel generator: directed table, random items, scoreboard.
`timescale 1ns / 1ps

module angular_spectrum_transfer_gen_tb;
  import ast_pkg::*;

  // one expected kernel sample
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               cut;
  } sample_t;

  // directed stimulus row: indices, plus an optional typed-in expectation
  typedef struct {
    logic [9:0] row;
    logic [9:0] col;
    bit         typed;
    sample_t    want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [9:0]         in_row_index = '0;
  logic [9:0]         in_col_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_re_part;
  logic signed [15:0] out_im_part;
  logic               out_past_cutoff;

  angular_spectrum_transfer_gen DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file, updated alongside each cfg write.
  logic [31:0] k_inv_lsq, k_col_sq, k_row_sq, k_turns;
  logic [9:0]  k_half_c, k_half_r;

  sample_t kernel_q[$];   // expected samples, oldest first
  int      fails = 0;
  bit      rx_idle_ok = 1'b1;   // receiver allowed to stall
  bit      tx_idle_ok = 1'b1;

  function automatic logic [63:0] half_eff(logic [9:0] h);
    if (h == 0) return 64'd1;
    if (h > 10'(HALF_MAX)) return 64'(HALF_MAX);
    return 64'(h);
  endfunction

  // squared centered frequency index
  function automatic logic [63:0] freq_sq(logic [9:0] idx, logic [63:0] h);
    logic [63:0] m, a;
    m = (64'(idx) + h) % (2 * h);
    a = (m >= h) ? m - h : h - m;
    return a * a;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // sin(pi/2 * w/2^22) in Q1.15, 9th-order odd polynomial, Q2.30 Horner
  function automatic logic signed [15:0] qsine(logic [63:0] w);
    logic [63:0] u, u2, acc;
    u = w << 8;
    u2 = (u * u) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((acc * u2) >> 30);
    acc = 64'd85569306 - ((acc * u2) >> 30);
    acc = 64'd693598669 - ((acc * u2) >> 30);
    acc = 64'd1686629713 - ((acc * u2) >> 30);
    acc = (acc * u) >> 30;
    acc = (acc + (64'd1 << 14)) >> 15;
    if (acc > 64'd32767) acc = 64'd32767;
    return 16'(acc);
  endfunction

  function automatic sample_t kernel_sample(logic [9:0] row, logic [9:0] col);
    sample_t s;
    logic [63:0] terms, root, phase, w;
    logic signed [15:0] sn, cs;
    terms = freq_sq(col, half_eff(k_half_c)) * 64'(k_col_sq)
          + freq_sq(row, half_eff(k_half_r)) * 64'(k_row_sq);
    s = '0;
    if (terms > 64'(k_inv_lsq)) begin
      s.cut = 1'b1;   // evanescent: zero output
    end else begin
      root = int_root((64'(k_inv_lsq) - terms) << 16);
      phase = ((root * 64'(k_turns)) >> 16) & 64'hFF_FFFF;
      w = phase & 64'h3F_FFFF;
      sn = qsine(w);
      cs = qsine((64'd1 << 22) - w);
      case (phase[23:22])
        2'd0: begin s.re = cs;  s.im = sn;  end
        2'd1: begin s.re = -sn; s.im = cs;  end
        2'd2: begin s.re = -cs; s.im = -sn; end
        default: begin s.re = sn; s.im = -cs; end
      endcase
    end
    return s;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_INV_LAMBDA_SQ:  k_inv_lsq = val;
      REG_COL_STEP_SQ:    k_col_sq = val;
      REG_ROW_STEP_SQ:    k_row_sq = val;
      REG_TURNS_PER_UNIT: k_turns = val;
      REG_HALF_COLS:      k_half_c = val[9:0];
      REG_HALF_ROWS:      k_half_r = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] il, logic [31:0] cs, logic [31:0] rs,
                         logic [31:0] tp, logic [9:0] hc, logic [9:0] hr);
    cfg_write(REG_INV_LAMBDA_SQ, il);
    cfg_write(REG_COL_STEP_SQ, cs);
    cfg_write(REG_ROW_STEP_SQ, rs);
    cfg_write(REG_TURNS_PER_UNIT, tp);
    cfg_write(REG_HALF_COLS, {22'(0), hc});
    cfg_write(REG_HALF_ROWS, {22'(0), hr});
  endtask

  // Drive one input transaction; called at a falling edge, returns at one.
  // Valid stays up after acceptance so the next call can follow without a gap.
  task automatic send_index(logic [9:0] row, logic [9:0] col);
    while (tx_idle_ok && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_index <= row;
    in_col_index <= col;
    kernel_q.push_back(kernel_sample(row, col));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain: all results back, then a further wait for margin.
  task automatic drain;
    in_valid <= 1'b0;
    while (kernel_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // Receiver back-pressure, changes on the falling edge.
  always @(negedge clk) begin
    out_ready <= !(rx_idle_ok && $urandom_range(99) < 20);
  end

  // Scoreboard: sample on the rising edge.
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_valid && out_ready) begin
      if (kernel_q.size() == 0) begin
        $display("%0t: unexpected transaction re=%0d im=%0d cut=%0b", $time,
                 out_re_part, out_im_part, out_past_cutoff);
        fails++;
      end else begin
        e = kernel_q.pop_front();
        if (out_re_part !== e.re) begin
          $display("%0t: re_part expected %0d actual %0d", $time, e.re, out_re_part);
          fails++;
        end
        if (out_im_part !== e.im) begin
          $display("%0t: im_part expected %0d actual %0d", $time, e.im, out_im_part);
          fails++;
        end
        if (out_past_cutoff !== e.cut) begin
          $display("%0t: past_cutoff expected %0b actual %0b", $time, e.cut,
                   out_past_cutoff);
          fails++;
        end
      end
    end
  end

  dir_row_t dir_tab[$];

  function automatic dir_row_t mk(logic [9:0] r, logic [9:0] c, bit t,
                                  logic signed [15:0] re, logic signed [15:0] im,
                                  logic cut);
    dir_row_t d;
    d.row = r; d.col = c; d.typed = t;
    d.want = '{re: re, im: im, cut: cut};
    return d;
  endfunction

  initial begin
    sample_t got_pred;
    logic [31:0] il, cs, rs;
    logic [9:0] hc, hr;
    int n;
    k_inv_lsq = 0; k_col_sq = 0; k_row_sq = 0; k_turns = 0;
    k_half_c = 10'd512; k_half_r = 10'd512;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: radicand zero everywhere -> re full scale, im zero.
    send_index(10'd0, 10'd0);
    send_index(10'd1023, 10'd1023);
    drain();

    // Evanescent: any nonzero term beats a zero inv_lambda_sq.
    cfg_write(REG_COL_STEP_SQ, 32'd1);
    dir_tab.push_back(mk(10'd0, 10'd0, 1, 16'sd32767, 16'sd0, 1'b0));  // zero frequency
    dir_tab.push_back(mk(10'd512, 10'd512, 1, 16'sd0, 16'sd0, 1'b1));  // kc=-512
    dir_tab.push_back(mk(10'd3, 10'd513, 1, 16'sd0, 16'sd0, 1'b1));
    foreach (dir_tab[i]) begin
      got_pred = kernel_sample(dir_tab[i].row, dir_tab[i].col);
      if (dir_tab[i].typed && got_pred !== dir_tab[i].want) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i,
                 dir_tab[i].want, got_pred);
        fails++;
      end
      send_index(dir_tab[i].row, dir_tab[i].col);
    end
    drain();

    // Extremes of every register, half sizes zero (as one) and saturating.
    set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 10'd0, 10'd1023);
    send_index(10'd0, 10'd1023);
    send_index(10'd1023, 10'd0);
    drain();
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000, 10'd1, 10'd1);
    send_index(10'd0, 10'd0);
    send_index(10'd1, 10'd1);
    send_index(10'd1023, 10'd512);
    drain();
    // small sizes, indices beyond the size in use wrap
    set_all(32'h0040_0000, 32'h0000_1000, 32'h0000_2000, 32'h0123_4567, 10'd4, 10'd3);
    for (int i = 0; i < 12; i++) send_index(10'(i * 97), 10'(1023 - i * 61));
    drain();

    // Random part: several settings, with a no-idle stretch in the middle.
    for (int ph = 0; ph < 10; ph++) begin
      il = $urandom(); cs = $urandom() >> $urandom_range(31);
      rs = $urandom() >> $urandom_range(31);
      hc = 10'($urandom_range(1023)); hr = 10'($urandom_range(1023));
      if (ph == 3) begin cs = 0; rs = 0; end
      if (ph == 4) begin il = 32'hFFFF_FFFF; hc = 10'd512; hr = 10'd512; end
      set_all(il, cs, rs, $urandom(), hc, hr);
      rx_idle_ok = (ph != 5);
      tx_idle_ok = (ph != 5);
      n = 125;
      for (int i = 0; i < n; i++)
        send_index(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      drain();
    end
    rx_idle_ok = 1'b1;
    tx_idle_ok = 1'b1;

    if (fails == 0 && kernel_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== angular_spectrum_transfer_gen.f =====
hw/rtl/ast_pkg.sv
hw/rtl/ast_mod_cell.sv
hw/rtl/ast_root_cell.sv
hw/rtl/ast_horner_cell.sv
hw/rtl/angular_spectrum_transfer_gen.sv
hw/rtl/ast_checker.sv
dv/angular_spectrum_transfer_gen_tb.sv
